// ===== hw/rtl/scbp_pkg.sv =====
// Shared types and constants of the size-class buffer pool.
package scbp_pkg;

  // Configuration register indexes and port widths
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROWTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE = 2'd2;

  // Register widths and reset values
  localparam int BASE_W = 17;
  localparam int GROWTH_W = 3;
  localparam int SIZE_W = 32;
  localparam logic [BASE_W-1:0] BASE_RST = 17'd64;
  localparam logic [GROWTH_W-1:0] GROWTH_RST = 3'd2;
  localparam logic [SIZE_W-1:0] MAX_RST = 32'd2097152;

  // Result status codes
  localparam logic [2:0] ST_POPPED = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_ALLOC_BIG = 3'd2;
  localparam logic [2:0] ST_FREED = 3'd3;
  localparam logic [2:0] ST_FREE_BIG = 3'd4;
  localparam logic [2:0] ST_FULL = 3'd5;

  // Request beat
  typedef struct packed {
    logic        req_type;
    logic [31:0] req_size;
    logic [31:0] buf_handle;
  } req_t;

  // Result beat
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  class_index;
    logic [31:0] class_size;
    logic [31:0] out_handle;
  } rsp_t;

  // Class lookup outcome
  typedef struct packed {
    logic              hit;
    logic [SIZE_W-1:0] size;
  } lkp_t;

  // Size table sweep status
  typedef struct packed {
    logic busy;
    logic clr;
  } swp_t;

endpackage

// ===== hw/rtl/scbp_class_map.sv =====
// Config registers, class size table sweep and request-to-class lookup.
module scbp_class_map #(
  parameter int NUM_CLASSES = 16,
  parameter int CLS_W = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [scbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scbp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [scbp_pkg::SIZE_W-1:0]     req_size,
  output logic [CLS_W-1:0]               cls,
  output scbp_pkg::lkp_t                 lkp,
  output scbp_pkg::swp_t                 swp,
  output logic [CLS_W-1:0]               swp_idx
);
  import scbp_pkg::*;

  logic [BASE_W-1:0]   base_r;
  logic [GROWTH_W-1:0] growth_r;
  logic [SIZE_W-1:0]   max_r;
  logic                sweep_r;
  logic                clr_r;
  logic [CLS_W-1:0]    idx_r;
  logic [SIZE_W-1:0]   sz_r;
  logic [SIZE_W-1:0]   tbl_r [NUM_CLASSES];
  logic [SIZE_W-1:0]   cur_sz;
  logic [SIZE_W+GROWTH_W-1:0] prod;
  logic [NUM_CLASSES-1:0] fit;
  logic                cfg_hit;

  // Registers in the list restart the size sweep; others are dropped
  assign cfg_hit = cfg_we && (cfg_index == CFG_BASE_SIZE || cfg_index == CFG_GROWTH ||
                              cfg_index == CFG_MAX_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= BASE_RST;
      growth_r <= GROWTH_RST;
      max_r    <= MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_SIZE: base_r   <= cfg_wdata[BASE_W-1:0];
        CFG_GROWTH:    growth_r <= cfg_wdata[GROWTH_W-1:0];
        CFG_MAX_SIZE:  max_r    <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // One class size per cycle: size(i) = sat(size(i-1) * growth)
  assign cur_sz = (idx_r == '0) ? SIZE_W'(base_r) : sz_r;
  assign prod   = (SIZE_W+GROWTH_W)'(cur_sz) * (SIZE_W+GROWTH_W)'(growth_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= 1'b1;
      clr_r   <= 1'b1;
      idx_r   <= '0;
    end else if (cfg_hit) begin
      sweep_r <= 1'b1;
      idx_r   <= '0;
    end else if (sweep_r) begin
      if (idx_r == CLS_W'(NUM_CLASSES - 1)) begin
        sweep_r <= 1'b0;
        clr_r   <= 1'b0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sweep_r) begin
      tbl_r[idx_r] <= cur_sz;
      sz_r         <= (|prod[SIZE_W+GROWTH_W-1:SIZE_W]) ? '1 : prod[SIZE_W-1:0];
    end
  end

  assign swp.busy = sweep_r;
  assign swp.clr  = clr_r;
  assign swp_idx  = idx_r;

  // Parallel fit compare, lowest fitting class wins
  always_comb begin
    for (int i = 0; i < NUM_CLASSES; i++) begin
      fit[i] = (tbl_r[i] >= req_size);
    end
  end

  always_comb begin
    cls = '0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (fit[i]) cls = CLS_W'(i);
    end
  end

  assign lkp.hit  = (|fit) && (req_size <= max_r);
  assign lkp.size = tbl_r[cls];

endmodule

// ===== hw/rtl/scbp_list_ctrl.sv =====
// Per-class FIFO free lists: pointer/count memory, handle memory and result register.
module scbp_list_ctrl #(
  parameter int NUM_CLASSES = 16,
  parameter int SLOTS_PER_CLASS = 256,
  parameter int HANDLE_BITS = 32,
  parameter int CLS_W = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc,
  input  scbp_pkg::req_t        req,
  input  logic [CLS_W-1:0]      cls,
  input  scbp_pkg::lkp_t        lkp,
  input  scbp_pkg::swp_t        swp,
  input  logic [CLS_W-1:0]      swp_idx,
  output logic                  busy,
  output logic                  out_valid,
  output scbp_pkg::rsp_t        rsp
);
  import scbp_pkg::*;

  localparam int PTR_W  = $clog2(SLOTS_PER_CLASS);
  localparam int CNT_W  = $clog2(SLOTS_PER_CLASS + 1);
  localparam int META_W = 2 * PTR_W + CNT_W;
  localparam int HS_W   = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
  localparam int HS_AW  = $clog2(NUM_CLASSES * SLOTS_PER_CLASS);
  localparam int HS_D   = NUM_CLASSES * SLOTS_PER_CLASS;

  // Memories: {read ptr, write ptr, count} per class, and the handle slots
  logic [META_W-1:0] meta_mem [NUM_CLASSES];
  logic [HS_W-1:0]   hs_mem [HS_D];

  logic [META_W-1:0] meta_q;
  logic [HS_W-1:0]   hs_q;
  logic              s1_r;
  logic              type_r;
  logic              hit_r;
  logic [CLS_W-1:0]  cls_r;
  logic [SIZE_W-1:0] csize_r;
  logic [HS_W-1:0]   hdl_r;
  logic              out_v_r;
  logic              pop_r;
  logic [2:0]        st_r;
  logic [3:0]        idx_out_r;
  logic [SIZE_W-1:0] size_out_r;

  logic [PTR_W-1:0]  rp, wp, rp_nxt, wp_nxt;
  logic [CNT_W-1:0]  cnt;
  logic              cnt_zero, cnt_full, pop, push;
  logic [2:0]        st_nxt;
  logic              meta_we;
  logic [CLS_W-1:0]  meta_wa;
  logic [META_W-1:0] meta_wd;
  logic [HS_AW-1:0]  hs_ra, hs_wa;
  logic [PTR_W:0]    occ;
  logic              occ_ok;

  // Meta read is issued at the accept edge with the looked-up class
  always_ff @(posedge clk) begin
    if (acc) meta_q <= meta_mem[cls];
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= 1'b0;
    end else begin
      s1_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      type_r  <= req.req_type;
      hit_r   <= lkp.hit;
      cls_r   <= cls;
      csize_r <= lkp.size;
      hdl_r   <= req.buf_handle[HS_W-1:0];
    end
  end

  // Decode the list state and plan the update
  assign {rp, wp, cnt} = meta_q;
  assign cnt_zero = (cnt == '0);
  assign cnt_full = (cnt == CNT_W'(SLOTS_PER_CLASS));
  assign pop  = s1_r && hit_r && !type_r && !cnt_zero;
  assign push = s1_r && hit_r && type_r && !cnt_full;
  assign rp_nxt = (rp == PTR_W'(SLOTS_PER_CLASS - 1)) ? '0 : rp + 1'b1;
  assign wp_nxt = (wp == PTR_W'(SLOTS_PER_CLASS - 1)) ? '0 : wp + 1'b1;

  always_comb begin
    if (!hit_r) begin
      st_nxt = type_r ? ST_FREE_BIG : ST_ALLOC_BIG;
    end else if (type_r) begin
      st_nxt = cnt_full ? ST_FULL : ST_FREED;
    end else begin
      st_nxt = cnt_zero ? ST_EMPTY : ST_POPPED;
    end
  end

  // Write back: item update, or zeroing during the clearing pass after reset
  always_comb begin
    meta_we = 1'b0;
    meta_wa = cls_r;
    meta_wd = meta_q;
    if (swp.busy && swp.clr) begin
      meta_we = 1'b1;
      meta_wa = swp_idx;
      meta_wd = '0;
    end else if (pop) begin
      meta_we = 1'b1;
      meta_wd = {rp_nxt, wp, cnt - 1'b1};
    end else if (push) begin
      meta_we = 1'b1;
      meta_wd = {rp, wp_nxt, cnt + 1'b1};
    end
  end

  // Handle slot addresses: class base plus ring pointer
  assign hs_ra = HS_AW'(cls_r) * HS_AW'(SLOTS_PER_CLASS) + HS_AW'(rp);
  assign hs_wa = HS_AW'(cls_r) * HS_AW'(SLOTS_PER_CLASS) + HS_AW'(wp);

  always_ff @(posedge clk) begin
    if (push) hs_mem[hs_wa] <= hdl_r;
  end

  always_ff @(posedge clk) begin
    if (pop) hs_q <= hs_mem[hs_ra];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_r) begin
      pop_r      <= pop;
      st_r       <= st_nxt;
      idx_out_r  <= hit_r ? 4'(cls_r) : '0;
      size_out_r <= hit_r ? csize_r : '0;
    end
  end

  assign busy            = s1_r;
  assign out_valid       = out_v_r;
  assign rsp.status      = st_r;
  assign rsp.class_index = idx_out_r;
  assign rsp.class_size  = size_out_r;
  assign rsp.out_handle  = pop_r ? 32'(hs_q) : '0;

  // Ring occupancy derived from the pointers, for checking the count
  assign occ = (wp >= rp) ? ({1'b0, wp} - {1'b0, rp})
                          : ({1'b0, wp} + (PTR_W+1)'(SLOTS_PER_CLASS) - {1'b0, rp});
  assign occ_ok = cnt_full ? (wp == rp) : ((PTR_W+1)'(cnt) == occ);

  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n) s1_r |=> out_v_r && !s1_r)
    else $error("request did not produce exactly one result beat");
  a_no_sweep: assert property (@(posedge clk) disable iff (!rst_n) !(s1_r && swp.busy))
    else $error("request in flight during size table sweep");
  a_cnt_rng: assert property (@(posedge clk) disable iff (!rst_n)
                              s1_r |-> cnt <= CNT_W'(SLOTS_PER_CLASS))
    else $error("free count beyond list depth");
  a_occ: assert property (@(posedge clk) disable iff (!rst_n) s1_r |-> occ_ok)
    else $error("free count disagrees with ring pointers");

endmodule

// ===== hw/rtl/size_class_buffer_pool_core.sv =====
// Top level of the size-class buffer pool: request port, result port, config port.
//
// Usage:
//  - Request channel: drive in_req and raise start; a beat is taken at a rising
//    edge where start is high and busy is low. req_type 0 allocates, 1 frees.
//  - Result channel: exactly one result beat per request, on out_rsp while
//    out_valid is high for one cycle. The receiver cannot stall it.
//  - Timing: the request register loads at the accept edge, then the result
//    register. Busy stays high while a request is in the request register, set
//    by the read-modify-write of the per-class pointer/count memory.
//  - Config: cfg_we with cfg_index (0 base size, 1 growth, 2 max size) and
//    cfg_wdata writes a register at once. Each write rebuilds the class size
//    table, one class per cycle, with busy held high.
//  - Reset (rst_n low, synchronous): registers return to defaults and a pass
//    rebuilds the size table and zeroes every class's pointers and count; busy
//    stays high until it ends. Handle slots are not cleared; only slots written
//    by a free are ever read back.
module size_class_buffer_pool_core #(
  parameter int NUM_CLASSES = 16,
  parameter int SLOTS_PER_CLASS = 256,
  parameter int HANDLE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  scbp_pkg::req_t                  in_req,
  output logic                            out_valid,
  output scbp_pkg::rsp_t                  out_rsp,
  input  logic                            cfg_we,
  input  logic [scbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scbp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import scbp_pkg::*;

  localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  logic             acc;
  logic             lc_busy;
  logic [CLS_W-1:0] cls;
  logic [CLS_W-1:0] swp_idx;
  lkp_t             lkp;
  swp_t             swp;

  assign busy = swp.busy | lc_busy;
  assign acc  = start & ~busy;

  scbp_class_map #(
    .NUM_CLASSES (NUM_CLASSES),
    .CLS_W       (CLS_W)
  ) u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req_size  (in_req.req_size),
    .cls       (cls),
    .lkp       (lkp),
    .swp       (swp),
    .swp_idx   (swp_idx)
  );

  scbp_list_ctrl #(
    .NUM_CLASSES     (NUM_CLASSES),
    .SLOTS_PER_CLASS (SLOTS_PER_CLASS),
    .HANDLE_BITS     (HANDLE_BITS),
    .CLS_W           (CLS_W)
  ) u_lists (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .req       (in_req),
    .cls       (cls),
    .lkp       (lkp),
    .swp       (swp),
    .swp_idx   (swp_idx),
    .busy      (lc_busy),
    .out_valid (out_valid),
    .rsp       (out_rsp)
  );

endmodule
